### hw/rtl/pid_with_bang_bang_unit_defines.svh
// Assertion macros shared by the checker of the PID unit.
// Included by files that carry concurrent assertions.
`ifndef PID_WITH_BANG_BANG_UNIT_DEFINES_SVH
`define PID_WITH_BANG_BANG_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PBB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define PBB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/pbb_pkg.sv
// Package of the PID unit: result codes, register indexes and the serial control struct.
// No dependencies.
`timescale 1ns / 1ps
package pbb_pkg;
  localparam logic [2:0] ACT_HELD = 3'd0;
  localparam logic [2:0] ACT_PID  = 3'd1;
  localparam logic [2:0] ACT_BMAX = 3'd2;
  localparam logic [2:0] ACT_BMIN = 3'd3;
  localparam logic [2:0] ACT_STOP = 3'd4;

  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_GAIN_P   = 3'd1;
  localparam logic [2:0] REG_GAIN_I   = 3'd2;
  localparam logic [2:0] REG_GAIN_D   = 3'd3;
  localparam logic [2:0] REG_BANG_ON  = 3'd4;
  localparam logic [2:0] REG_BANG_OFF = 3'd5;
  localparam logic [2:0] REG_DRIVE_MIN = 3'd6;
  localparam logic [2:0] REG_DRIVE_MAX = 3'd7;

  // Start and busy flags of one serial operation.
  typedef struct packed {
    logic start;
    logic busy;
  } sctl_t;
endpackage

### hw/rtl/pbb_mul.sv
// Shift-and-add signed multiplier, one multiplier bit per cycle.
// Depends on pbb_pkg.
`timescale 1ns / 1ps
module pbb_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [32:0]  a,
  input  logic signed [47:0]  b,
  output pbb_pkg::sctl_t      stat,
  output logic signed [80:0]  prod
);
  import pbb_pkg::*;
  logic [5:0] cnt;
  logic signed [80:0] acc;
  logic signed [80:0] mcand;
  logic [47:0] mplier;
  logic busy;

  // The top multiplier bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      acc <= '0;
      mcand <= 81'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        if (cnt == 6'd47) acc <= acc - mcand;
        else acc <= acc + mcand;
      end
      mcand <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt <= cnt + 6'd1;
      if (cnt == 6'd47) busy <= 1'b0;
    end
  end

  assign prod = acc;
  assign stat.start = start;
  assign stat.busy = busy;
endmodule

### hw/rtl/pbb_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pbb_pkg.
`timescale 1ns / 1ps
module pbb_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        num,
  input  logic [31:0]        den,
  output pbb_pkg::sctl_t     stat,
  output logic [63:0]        quot
);
  import pbb_pkg::*;
  logic [6:0] cnt;
  logic [32:0] rem;
  logic [63:0] q;
  logic [32:0] trial;
  logic busy;

  assign trial = {rem[31:0], q[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      rem <= '0;
      q <= num;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        q <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[31:0], q[63]};
        q <= {q[62:0], 1'b0};
      end
      cnt <= cnt + 7'd1;
      if (cnt == 7'd63) busy <= 1'b0;
    end
  end

  assign quot = q;
  assign stat.start = start;
  assign stat.busy = busy;
endmodule

### hw/rtl/pid_with_bang_bang_unit.sv
// PID controller with bang-bang override, Q16.16, top level.
// Depends on pbb_pkg, pbb_mul and pbb_div.
//
// Usage: configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Slave stream s_axis: tuser = operation (1 stop, 0 run), tdata packs now_ms,
// measurement and near_threshold. Master stream m_axis returns one item per
// input item: tuser = action, tdata packs drive, at_setpoint, stopped_flag,
// integral_value.
// One item is processed at a time. A stop item goes from acceptance straight to
// the output state; a bang or held item passes through the decide state first.
// A PID update runs one serial multiply for |s|*dT, two serial divides and
// three serial multiplies. The shared bit-serial divider and multiplier serve
// all these steps. After the result enters the output register, the unit passes
// through a wait state before the input is taken again. Reset clears the
// configuration and the controller state to zero, but not the datapath and
// output data registers.
// A stalled receiver holds the result register; a finished item then waits
// until the register is free, and the input stays blocked meanwhile.
`timescale 1ns / 1ps
module pid_with_bang_bang_unit #(
  parameter int TIME_STEP_MS = 1000
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_ms[31:0], measurement[63:32], near_threshold[94:64], zero pad
  input  logic [95:0]  s_axis_tdata,
  // operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // drive[31:0], at_setpoint[32], stopped_flag[33], integral_value[81:34], pad
  output logic [87:0]  m_axis_tdata,
  // action
  output logic [2:0]   m_axis_tuser
);
  import pbb_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_DIV_I = 4'd2;
  localparam logic [3:0] S_DIV_D = 4'd3;
  localparam logic [3:0] S_MUL_P = 4'd4;
  localparam logic [3:0] S_MUL_I = 4'd5;
  localparam logic [3:0] S_MUL_D = 4'd6;
  localparam logic [3:0] S_SUM = 4'd7;
  localparam logic [3:0] S_CLAMP = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_WAIT = 4'd10;

  logic signed [31:0] setpoint, gain_p, gain_i, gain_d, drive_min, drive_max;
  logic [30:0] bang_on_limit, bang_off_limit;

  logic signed [31:0] last_measurement, previous_error, held_drive;
  logic [31:0] last_update_ms;
  logic signed [47:0] error_integral;
  logic is_stopped;

  logic [3:0] state;
  logic [31:0] now_ms, dt;
  logic [30:0] thr;
  logic [2:0] action;
  logic signed [31:0] e;
  logic signed [33:0] sum_ed;
  logic signed [82:0] acc;
  logic sub_started;

  logic mul_start, div_start;
  logic signed [32:0] mul_a;
  logic signed [47:0] mul_b;
  logic signed [80:0] mul_p;
  logic [63:0] div_num, div_q;
  logic [31:0] div_den;
  sctl_t mul_st, div_st;

  // Error in full precision for the bang tests and at-setpoint flag.
  logic signed [32:0] err_x;
  logic signed [33:0] neg_err;
  logic [32:0] abs_err;
  assign err_x = 33'(setpoint) - 33'(last_measurement);
  assign neg_err = -34'(err_x);
  assign abs_err = err_x[32] ? neg_err[32:0] : err_x;

  logic signed [31:0] e_sat;
  always_comb begin
    if (err_x > 33'sh0_7FFF_FFFF) e_sat = 32'sh7FFF_FFFF;
    else if (err_x < -33'sh0_8000_0000) e_sat = 32'sh8000_0000;
    else e_sat = err_x[31:0];
  end

  logic [33:0] sum_mag;
  logic [32:0] dif_mag;
  logic signed [32:0] dif_ed;
  assign dif_ed = 33'(e) - 33'(previous_error);
  assign sum_mag = sum_ed[33] ? 34'(-sum_ed) : 34'(sum_ed);
  assign dif_mag = dif_ed[32] ? 33'(-dif_ed) : 33'(dif_ed);

  logic signed [65:0] int_sum;
  logic signed [47:0] int_sat;
  logic signed [63:0] inc;
  assign inc = sum_ed[33] ? -$signed(div_q) : $signed(div_q);
  // The increment can pass 48 bits, so the sum stays wide until it saturates.
  assign int_sum = 66'(error_integral) + 66'(inc);
  always_comb begin
    if (int_sum > 66'sh0_7FFF_FFFF_FFFF) int_sat = 48'sh7FFF_FFFF_FFFF;
    else if (int_sum < -66'sh0_8000_0000_0000) int_sat = 48'sh8000_0000_0000;
    else int_sat = int_sum[47:0];
  end

  logic signed [47:0] derr;
  logic signed [63:0] dq_s;
  assign dq_s = dif_ed[32] ? -$signed(div_q) : $signed(div_q);
  assign derr = dq_s[47:0];

  logic signed [82:0] term;
  assign term = 83'(mul_p >>> 16);

  logic signed [82:0] vmax, vmin;
  assign vmax = 83'sd2 <<< 32;
  assign vmin = -(83'sd2 <<< 32);
  logic signed [82:0] v;
  always_comb begin
    if (acc >= (83'sd1 <<< 32)) v = vmax;
    else if (acc < -(83'sd1 <<< 32)) v = vmin;
    else v = acc;
  end

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a = 33'(gain_p);
    mul_b = 48'(e);
    div_num = 64'(sum_mag);
    div_den = 32'd2000;
    unique case (state)
      S_DIV_I: begin
        div_start = !sub_started;
      end
      S_DIV_D: begin
        div_start = !sub_started;
        // Times 1000 as 1024 - 16 - 8.
        div_num = (64'(dif_mag) << 10) - (64'(dif_mag) << 4) - (64'(dif_mag) << 3);
        div_den = (dt == 32'd0) ? 32'd1 : dt;
      end
      S_MUL_P: mul_start = !sub_started;
      S_MUL_I: begin
        mul_start = !sub_started;
        mul_a = 33'(gain_i);
        mul_b = error_integral;
      end
      S_MUL_D: begin
        mul_start = !sub_started;
        mul_a = 33'(gain_d);
        mul_b = derr;
      end
      default: ;
    endcase
  end

  // The integral numerator is |s| * dT, formed by the multiplier path below.
  logic [63:0] sdt;
  logic sdt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0; gain_p <= '0; gain_i <= '0; gain_d <= '0;
      bang_on_limit <= '0; bang_off_limit <= '0;
      drive_min <= '0; drive_max <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT: setpoint <= cfg_data;
        REG_GAIN_P: gain_p <= cfg_data;
        REG_GAIN_I: gain_i <= cfg_data;
        REG_GAIN_D: gain_d <= cfg_data;
        REG_BANG_ON: bang_on_limit <= cfg_data[30:0];
        REG_BANG_OFF: bang_off_limit <= cfg_data[30:0];
        REG_DRIVE_MIN: drive_min <= cfg_data;
        REG_DRIVE_MAX: drive_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last_measurement <= '0;
      last_update_ms <= '0;
      error_integral <= '0;
      previous_error <= '0;
      held_drive <= '0;
      is_stopped <= 1'b0;
      m_axis_tvalid <= 1'b0;
      sub_started <= 1'b0;
      sdt_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            now_ms <= s_axis_tdata[31:0];
            thr <= s_axis_tdata[94:64];
            if (s_axis_tuser) begin
              is_stopped <= 1'b1;
              last_update_ms <= s_axis_tdata[31:0];
              error_integral <= '0;
              previous_error <= '0;
              action <= ACT_STOP;
              state <= S_OUT;
            end else begin
              last_measurement <= s_axis_tdata[63:32];
              if (is_stopped) begin
                is_stopped <= 1'b0;
                last_update_ms <= s_axis_tdata[31:0];
                error_integral <= '0;
                previous_error <= '0;
              end
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          dt <= now_ms - last_update_ms;
          if (bang_on_limit != '0 && err_x > $signed({2'b00, bang_on_limit})) begin
            held_drive <= drive_max;
            last_update_ms <= now_ms;
            action <= ACT_BMAX;
            state <= S_OUT;
          end else if (bang_off_limit != '0
                       && neg_err > $signed({3'b000, bang_off_limit})) begin
            held_drive <= drive_min;
            last_update_ms <= now_ms;
            action <= ACT_BMIN;
            state <= S_OUT;
          end else if ((now_ms - last_update_ms) >= 32'(TIME_STEP_MS)) begin
            e <= e_sat;
            sum_ed <= 34'(e_sat) + 34'(previous_error);
            last_update_ms <= now_ms;
            action <= ACT_PID;
            sdt_ready <= 1'b0;
            sub_started <= 1'b0;
            state <= S_DIV_I;
          end else begin
            action <= ACT_HELD;
            state <= S_OUT;
          end
        end
        S_DIV_I: begin
          // trunc(s*dT/2000) = sign(s) * floor(|s|*dT/2000); |s|*dT from the multiplier.
          if (!sdt_ready) begin
            if (!sub_started) sub_started <= 1'b1;
            else if (!mul_st.busy) begin
              sdt <= mul_p[63:0];
              sdt_ready <= 1'b1;
              sub_started <= 1'b0;
            end
          end else if (!sub_started) begin
            sub_started <= 1'b1;
          end else if (!div_st.busy) begin
            error_integral <= int_sat;
            sub_started <= 1'b0;
            state <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (!sub_started) sub_started <= 1'b1;
          else if (!div_st.busy) begin
            sub_started <= 1'b0;
            acc <= '0;
            state <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          if (!sub_started) sub_started <= 1'b1;
          else if (!mul_st.busy) begin
            acc <= term;
            sub_started <= 1'b0;
            state <= S_MUL_I;
          end
        end
        S_MUL_I: begin
          if (!sub_started) sub_started <= 1'b1;
          else if (!mul_st.busy) begin
            acc <= acc + term;
            sub_started <= 1'b0;
            state <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          if (!sub_started) begin
            sub_started <= 1'b1;
            previous_error <= e;
          end else if (!mul_st.busy) begin
            acc <= acc + term;
            sub_started <= 1'b0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          acc <= v;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (acc < 83'(drive_min)) held_drive <= drive_min;
          else if (acc > 83'(drive_max)) held_drive <= drive_max;
          else held_drive <= acc[31:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= action;
            m_axis_tdata <= {6'd0, error_integral, is_stopped,
              (abs_err <= 33'(thr)), is_stopped ? 32'd0 : held_drive};
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // The integral step reuses the multiplier for |s|*dT before the divide.
  logic mul_pre;
  assign mul_pre = (state == S_DIV_I) && !sdt_ready && !sub_started;
  logic [63:0] div_num_i;
  assign div_num_i = sdt;
  logic signed [32:0] dt_s;
  assign dt_s = $signed({1'b0, dt});

  // Override operand routing for the integral product and divide.
  logic mul_start_x, div_start_x;
  logic signed [32:0] mul_a_x;
  logic signed [47:0] mul_b_x;
  logic [63:0] div_num_x;
  always_comb begin
    mul_start_x = mul_start;
    div_start_x = div_start;
    mul_a_x = mul_a;
    mul_b_x = mul_b;
    div_num_x = div_num;
    if (state == S_DIV_I) begin
      mul_start_x = mul_pre;
      div_start_x = sdt_ready && !sub_started;
      mul_a_x = dt_s;
      mul_b_x = 48'(sum_mag);
      div_num_x = div_num_i;
    end
  end

  pbb_mul u_mul (.clk, .rst, .start(mul_start_x), .a(mul_a_x), .b(mul_b_x),
    .stat(mul_st), .prod(mul_p));
  pbb_div u_div (.clk, .rst, .start(div_start_x), .num(div_num_x), .den(div_den),
    .stat(div_st), .quot(div_q));
endmodule

### hw/rtl/pbb_check.sv
// Port-level checker for the PID unit, bound to the top level.
// Depends on pbb_pkg and pid_with_bang_bang_unit_defines.svh.
`timescale 1ns / 1ps
`include "pid_with_bang_bang_unit_defines.svh"
module pbb_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import pbb_pkg::*;
  `PBB_ASSERT_IMP(a_stop_zero, clk, rst, m_axis_tvalid && m_axis_tuser == ACT_STOP,
    m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[33], "stop result must read zero drive")
  `PBB_ASSERT_IMP(a_action_range, clk, rst, m_axis_tvalid,
    m_axis_tuser <= ACT_STOP, "action code out of range")
  `PBB_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `PBB_ASSERT_NXT(a_one_at_time, clk, rst, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "second item taken while busy")
endmodule

bind pid_with_bang_bang_unit pbb_check u_pbb_check (.*);
